>>> sv/clws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clws_pkg
// Shared types and codes of the character LCD write sequencer.
// ----------------------------------------------------------------------------
package clws_pkg;

    localparam logic [1:0] OP_CMD  = 2'd0;
    localparam logic [1:0] OP_TEXT = 2'd1;
    localparam logic [1:0] OP_GOTO = 2'd2;

    localparam logic [2:0] REG_BUS_MODE      = 3'd0;
    localparam logic [2:0] REG_DISPLAY_LINES = 3'd1;
    localparam logic [2:0] REG_ROW1_BASE     = 3'd2;
    localparam logic [2:0] REG_ROW2_BASE     = 3'd3;
    localparam logic [2:0] REG_ROW3_BASE     = 3'd4;
    localparam logic [2:0] REG_ROW4_BASE     = 3'd5;

    localparam int unsigned CFG_WIDTH   = 7;
    localparam int unsigned INDEX_WIDTH = 3;

    localparam logic       RST_BUS_MODE      = 1'b0;
    localparam logic       RST_DISPLAY_LINES = 1'b1;
    localparam logic [6:0] RST_ROW1_BASE     = 7'd0;
    localparam logic [6:0] RST_ROW2_BASE     = 7'd64;
    localparam logic [6:0] RST_ROW3_BASE     = 7'd20;
    localparam logic [6:0] RST_ROW4_BASE     = 7'd84;

    localparam logic [7:0] SET_ADDR_CMD = 8'h80;

    typedef struct packed {
        logic       strobe;
        logic       rs;
        logic [7:0] bus;
        logic       status;
    } entry_t;

    typedef struct packed {
        entry_t [3:0] entry;
        logic [1:0]   last_idx;
    } plan_t;

    typedef struct packed {
        logic       bus_mode;
        logic       display_lines;
        logic [6:0] row1_base;
        logic [6:0] row2_base;
        logic [6:0] row3_base;
        logic [6:0] row4_base;
    } cfg_t;

endpackage

>>> sv/clws_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clws_decode
// Expands one request into its list of bus transfers or a status result.
// ----------------------------------------------------------------------------
module clws_decode #(
    parameter int CHARS_PER_LINE    = 20,
    parameter int MAX_TEXT_ONE_LINE = 40,
    parameter int MAX_TEXT_TWO_LINE = 80
) (
    input  logic [1:0]     op,
    input  logic [7:0]     byte_value,
    input  logic [2:0]     row,
    input  logic [7:0]     column,
    input  logic [7:0]     text_length,
    input  clws_pkg::cfg_t cfg,
    input  logic [7:0]     text_position,
    output clws_pkg::plan_t plan,
    output logic [7:0]     text_position_next
);

    localparam logic [8:0] LINE1_POS = 9'(CHARS_PER_LINE);
    localparam logic [8:0] LINE2_POS = 9'(2 * CHARS_PER_LINE);
    localparam logic [8:0] LINE3_POS = 9'(3 * CHARS_PER_LINE);
    localparam logic [8:0] LIMIT_ONE = 9'(MAX_TEXT_ONE_LINE);
    localparam logic [8:0] LIMIT_TWO = 9'(MAX_TEXT_TWO_LINE);

    logic       err;
    logic       two_bytes;
    logic [7:0] first_byte;
    logic       first_rs;
    logic [7:0] second_byte;
    logic [8:0] pos_ext;
    logic [8:0] pos_inc;
    logic [7:0] len_eff;
    logic [8:0] limit;
    logic [6:0] base;
    logic [6:0] goto_addr;
    logic       row_bad;
    logic       col_bad;
    clws_pkg::entry_t e_first_hi;
    clws_pkg::entry_t e_first_lo;
    clws_pkg::entry_t e_first_full;
    clws_pkg::entry_t e_second_hi;
    clws_pkg::entry_t e_second_lo;
    clws_pkg::entry_t e_second_full;
    clws_pkg::entry_t e_err;

    always_comb
    begin
        pos_ext   = {1'b0, text_position};
        pos_inc   = pos_ext + 9'd1;
        len_eff   = (text_length == 8'd0) ? 8'd1 : text_length;
        limit     = cfg.display_lines ? LIMIT_TWO : LIMIT_ONE;
        row_bad   = (row == 3'd0) || (row > 3'd4);
        col_bad   = (column == 8'd0) || ({1'b0, column} > LINE1_POS);

        if (!cfg.display_lines)
        begin
            base = (row == 3'd1) ? cfg.row1_base : cfg.row3_base;
        end
        else
        begin
            unique case (row)
                3'd1:    base = cfg.row1_base;
                3'd2:    base = cfg.row2_base;
                3'd3:    base = cfg.row3_base;
                default: base = cfg.row4_base;
            endcase
        end
        goto_addr = base + column[6:0] - 7'd1;

        err                = 1'b0;
        two_bytes          = 1'b0;
        first_byte         = byte_value;
        first_rs           = 1'b0;
        second_byte        = byte_value;
        text_position_next = text_position;

        unique case (op)
            clws_pkg::OP_CMD:
            begin
                first_byte = byte_value;
            end
            clws_pkg::OP_TEXT:
            begin
                if ({1'b0, text_length} > limit)
                begin
                    err                = 1'b1;
                    text_position_next = 8'd0;
                end
                else
                begin
                    priority if (cfg.display_lines && pos_ext == LINE1_POS)
                    begin
                        two_bytes  = 1'b1;
                        first_byte = clws_pkg::SET_ADDR_CMD | {1'b0, cfg.row2_base};
                    end
                    else if (cfg.display_lines && pos_ext == LINE2_POS)
                    begin
                        two_bytes  = 1'b1;
                        first_byte = clws_pkg::SET_ADDR_CMD | {1'b0, cfg.row3_base};
                    end
                    else if (cfg.display_lines && pos_ext == LINE3_POS)
                    begin
                        two_bytes  = 1'b1;
                        first_byte = clws_pkg::SET_ADDR_CMD | {1'b0, cfg.row4_base};
                    end
                    else
                    begin
                        first_rs = 1'b1;
                    end
                    text_position_next = (pos_inc >= {1'b0, len_eff}) ? 8'd0 : pos_inc[7:0];
                end
            end
            clws_pkg::OP_GOTO:
            begin
                if (row_bad || col_bad)
                begin
                    err = 1'b1;
                end
                else
                begin
                    first_byte = clws_pkg::SET_ADDR_CMD | {1'b0, goto_addr};
                end
            end
            default:
            begin
                err = 1'b1;
            end
        endcase

        e_err         = '{strobe: 1'b0, rs: 1'b0, bus: 8'd0, status: 1'b1};
        e_first_full  = '{strobe: 1'b1, rs: first_rs, bus: first_byte, status: 1'b0};
        e_first_hi    = '{strobe: 1'b1, rs: first_rs, bus: {first_byte[7:4], 4'd0},
                          status: 1'b0};
        e_first_lo    = '{strobe: 1'b1, rs: first_rs, bus: {first_byte[3:0], 4'd0},
                          status: 1'b0};
        e_second_full = '{strobe: 1'b1, rs: 1'b1, bus: second_byte, status: 1'b0};
        e_second_hi   = '{strobe: 1'b1, rs: 1'b1, bus: {second_byte[7:4], 4'd0},
                          status: 1'b0};
        e_second_lo   = '{strobe: 1'b1, rs: 1'b1, bus: {second_byte[3:0], 4'd0},
                          status: 1'b0};

        plan.entry[2] = e_second_hi;
        plan.entry[3] = e_second_lo;
        if (err)
        begin
            plan.entry[0] = e_err;
            plan.entry[1] = e_err;
            plan.last_idx = 2'd0;
        end
        else if (cfg.bus_mode)
        begin
            plan.entry[0] = e_first_hi;
            plan.entry[1] = e_first_lo;
            plan.last_idx = two_bytes ? 2'd3 : 2'd1;
        end
        else
        begin
            plan.entry[0] = e_first_full;
            plan.entry[1] = e_second_full;
            plan.last_idx = two_bytes ? 2'd1 : 2'd0;
        end
    end

endmodule

>>> sv/char_lcd_write_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_top
// Character LCD write sequencer: requests in, enable-strobed transfers out.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid / in_stall) carries one request per
// transaction: a raw command, one text character, or a go-to row/column.
// The output channel (out_valid / out_stall) carries one bus transfer or one
// status-only result per transaction; last marks the final result of a request.
// A request gives 1, 2 or 4 results (4 in four-bit mode with a line-change
// address command). The request is decoded into a transfer list register in
// the accept cycle; the output register then drains that list at one result
// per cycle while out_stall is low, the next request being accepted on the
// cycle the last result is loaded. Configuration registers are written
// through cfg_we / cfg_index / cfg_data; the user must write them only while
// the block is idle, as the block itself does not enforce it. Reset clears
// the text position, both handshake stages and loads the register reset
// values. While out_stall is high the output holds; once the list register
// is also full, in_stall rises.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_top #(
    parameter int CHARS_PER_LINE    = 20,
    parameter int MAX_TEXT_ONE_LINE = 40,
    parameter int MAX_TEXT_TWO_LINE = 80
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [6:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] op,
    input  logic [7:0] byte_value,
    input  logic [2:0] row,
    input  logic [7:0] column,
    input  logic [7:0] text_length,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       strobe_res,
    output logic       reg_select,
    output logic [7:0] bus_value,
    output logic       status,
    output logic       last
);

    clws_pkg::cfg_t   cfg_reg;
    clws_pkg::cfg_t   cfg_next;
    logic [7:0]       text_position_reg;
    logic [7:0]       text_position_next;
    logic [7:0]       decode_position;
    clws_pkg::plan_t  decode_plan;
    clws_pkg::plan_t  plan_reg;
    logic             plan_valid_reg;
    logic             plan_valid_next;
    logic [1:0]       plan_idx_reg;
    logic [1:0]       plan_idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    clws_pkg::entry_t out_entry_reg;
    logic             out_last_reg;
    logic             in_accept;
    logic             load_out;
    logic             plan_done;

    clws_decode #(
        .CHARS_PER_LINE    (CHARS_PER_LINE),
        .MAX_TEXT_ONE_LINE (MAX_TEXT_ONE_LINE),
        .MAX_TEXT_TWO_LINE (MAX_TEXT_TWO_LINE)
    ) u_decode (
        .op                 (op),
        .byte_value         (byte_value),
        .row                (row),
        .column             (column),
        .text_length        (text_length),
        .cfg                (cfg_reg),
        .text_position      (text_position_reg),
        .plan               (decode_plan),
        .text_position_next (decode_position)
    );

    always_comb
    begin
        load_out  = plan_valid_reg && (!out_valid_reg || !out_stall);
        plan_done = load_out && (plan_idx_reg == plan_reg.last_idx);
        in_stall  = plan_valid_reg && !plan_done;
        in_accept = in_valid && !in_stall;

        if (in_accept)
        begin
            plan_valid_next = 1'b1;
        end
        else if (plan_done)
        begin
            plan_valid_next = 1'b0;
        end
        else
        begin
            plan_valid_next = plan_valid_reg;
        end

        if (in_accept)
        begin
            plan_idx_next = 2'd0;
        end
        else if (load_out)
        begin
            plan_idx_next = plan_idx_reg + 2'd1;
        end
        else
        begin
            plan_idx_next = plan_idx_reg;
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end

        text_position_next = in_accept ? decode_position : text_position_reg;

        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                clws_pkg::REG_BUS_MODE:      cfg_next.bus_mode      = cfg_data[0];
                clws_pkg::REG_DISPLAY_LINES: cfg_next.display_lines = cfg_data[0];
                clws_pkg::REG_ROW1_BASE:     cfg_next.row1_base     = cfg_data;
                clws_pkg::REG_ROW2_BASE:     cfg_next.row2_base     = cfg_data;
                clws_pkg::REG_ROW3_BASE:     cfg_next.row3_base     = cfg_data;
                clws_pkg::REG_ROW4_BASE:     cfg_next.row4_base     = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bus_mode      <= clws_pkg::RST_BUS_MODE;
            cfg_reg.display_lines <= clws_pkg::RST_DISPLAY_LINES;
            cfg_reg.row1_base     <= clws_pkg::RST_ROW1_BASE;
            cfg_reg.row2_base     <= clws_pkg::RST_ROW2_BASE;
            cfg_reg.row3_base     <= clws_pkg::RST_ROW3_BASE;
            cfg_reg.row4_base     <= clws_pkg::RST_ROW4_BASE;
            text_position_reg     <= 8'd0;
            plan_valid_reg        <= 1'b0;
            plan_idx_reg          <= 2'd0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            cfg_reg           <= cfg_next;
            text_position_reg <= text_position_next;
            plan_valid_reg    <= plan_valid_next;
            plan_idx_reg      <= plan_idx_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            plan_reg <= decode_plan;
        end
        if (load_out)
        begin
            out_entry_reg <= plan_reg.entry[plan_idx_reg];
            out_last_reg  <= (plan_idx_reg == plan_reg.last_idx);
        end
    end

    assign out_valid  = out_valid_reg;
    assign strobe_res = out_entry_reg.strobe;
    assign reg_select = out_entry_reg.rs;
    assign bus_value  = out_entry_reg.bus;
    assign status     = out_entry_reg.status;
    assign last       = out_last_reg;

    a_status_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_entry_reg.status |-> out_last_reg && !out_entry_reg.strobe)
        else $error("status result not a lone final result");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        plan_valid_reg |-> plan_idx_reg <= plan_reg.last_idx)
        else $error("transfer index past end of list");

    a_empty_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !plan_valid_reg |-> !in_stall)
        else $error("input stalled with empty transfer list");

    a_accept_fills_list: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> plan_valid_reg && plan_idx_reg == 2'd0)
        else $error("accepted request not in transfer list");

    a_nibble_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_entry_reg.strobe && cfg_reg.bus_mode
        |-> out_entry_reg.bus[3:0] == 4'd0)
        else $error("four-bit transfer with low bits set");

endmodule
